// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the timed PWM pulse output.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// ----- src/tpwm_pkg.sv -----
// Package of the timed PWM pulse output: widths, codes, state type and helpers.
// Used by tpwm_div, timed_pwm_pulse_output and the testbench; depends on nothing.
package tpwm_pkg;

	localparam int FREQ_W   = 20;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 64;
	localparam int DUTY_W   = 7;
	localparam int CHAN_W   = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [COUNT_W-1:0] MS_PER_S  = COUNT_W'(1000);
	localparam logic [DUTY_W-1:0]  FULL_DUTY = DUTY_W'(100);
	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

	localparam logic [FREQ_W-1:0] FREQ_RESET   = FREQ_W'(1);
	localparam logic [CHAN_W-1:0] CHAN_RESET   = CHAN_W'(1);
	localparam logic [CHAN_W-1:0] CHAN_LOW     = CHAN_W'(1);
	localparam logic [CHAN_W-1:0] CHAN_HIGH    = CHAN_W'(4);
	localparam logic              ACTIVE_RESET = 1'b1;

	// The divider retires two quotient bits per cycle over the whole dividend.
	localparam int DIV_STEPS = COUNT_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		OP_ON      = 3'd0,
		OP_OFF     = 3'd1,
		OP_LOCK    = 3'd2,
		OP_TICK    = 3'd3,
		OP_COMPARE = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ   = 3'd0,
		CFG_ADD    = 3'd1,
		CFG_DUTY   = 3'd2,
		CFG_CHAN   = 3'd3,
		CFG_ACTIVE = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DIFF,
		ST_EXEC
	} state_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

// ----- src/tpwm_div.sv -----
// Radix-4 restoring divider: 64-bit dividend by 20-bit divisor, low 32 quotient bits.
// Depends on tpwm_pkg for widths and the step count.
module tpwm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tpwm_pkg::COUNT_W-1:0]      dividend,
	input  logic [tpwm_pkg::FREQ_W-1:0]       divisor,
	output logic                              done,
	output logic [tpwm_pkg::TIME_W-1:0]       quotient
);

	localparam logic [tpwm_pkg::DIV_CNT_W-1:0] LAST_STEP =
		tpwm_pkg::DIV_CNT_W'(tpwm_pkg::DIV_STEPS - 1);

	logic                               busy_q;
	logic                               done_q;
	logic [tpwm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [tpwm_pkg::COUNT_W-1:0]       dvd_q;
	logic [tpwm_pkg::FREQ_W-1:0]        rem_q;
	logic [tpwm_pkg::FREQ_W-1:0]        div_q;
	logic [tpwm_pkg::TIME_W-1:0]        quo_q;

	logic [tpwm_pkg::FREQ_W:0] r1;
	logic [tpwm_pkg::FREQ_W:0] r1s;
	logic [tpwm_pkg::FREQ_W:0] r2;
	logic [tpwm_pkg::FREQ_W:0] r2s;
	logic                      ge1;
	logic                      ge2;

	always_comb begin
		r1  = {rem_q, dvd_q[tpwm_pkg::COUNT_W-1]};
		ge1 = r1 >= {1'b0, div_q};
		r1s = ge1 ? (r1 - {1'b0, div_q}) : r1;
		r2  = {r1s[tpwm_pkg::FREQ_W-1:0], dvd_q[tpwm_pkg::COUNT_W-2]};
		ge2 = r2 >= {1'b0, div_q};
		r2s = ge2 ? (r2 - {1'b0, div_q}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tpwm_pkg::COUNT_W-3:0], 2'b00};
			rem_q <= r2s[tpwm_pkg::FREQ_W-1:0];
			quo_q <= {quo_q[tpwm_pkg::TIME_W-3:0], ge1, ge2};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/timed_pwm_pulse_output.sv -----
// Timed PWM pulse output: top level with request handling, pulse state and output register.
// Depends on tpwm_pkg, tpwm_div and assert_macros.svh.
//
// Requests enter on the in channel (valid/ready) and each one yields exactly one
// result on the out channel (valid/ready). The block takes one request at a time.
// On, off, lock and compare requests go from acceptance straight to the exec state.
// An overflow tick converts the tick count to milliseconds in the serial divider,
// which retires two quotient bits per cycle over 64 dividend bits, and then
// passes through the difference state to exec. in_ready returns in the cycle
// after the result is loaded into the output register.
// The output register holds a finished result while the receiver stalls; the
// next request is still accepted and worked, and waits only to be committed
// until the previous result has been taken.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must do so
// only while no request is in flight, which the block does not enforce. Reset clears
// the tick count and the pulse state, and sets the configuration to 1 Hz, replace mode,
// zero duty, compare channel 1 and an active-high pin; the internal level resets low.
`include "assert_macros.svh"

module timed_pwm_pulse_output (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpwm_pkg::FREQ_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          opcode,
	input  logic [tpwm_pkg::TIME_W-1:0]         duration_ms,
	input  logic [tpwm_pkg::CHAN_W-1:0]         match_channel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pin_level,
	output logic                                finish_event,
	output logic                                tick_event,
	output logic [tpwm_pkg::TIME_W-1:0]         remaining_ms,
	output logic [tpwm_pkg::TIME_W-1:0]         initial_ms,
	output logic                                idle
);

	// Configuration registers.
	logic [tpwm_pkg::FREQ_W-1:0] freq_q;
	logic                        add_q;
	logic [tpwm_pkg::DUTY_W-1:0] duty_q;
	logic [tpwm_pkg::CHAN_W-1:0] chan_q;
	logic                        active_q;

	// Pulse state; scaled_q holds the tick count times 1000.
	logic [tpwm_pkg::COUNT_W-1:0] scaled_q;
	logic [tpwm_pkg::TIME_W-1:0]  last_ms_q;
	logic [tpwm_pkg::TIME_W-1:0]  remaining_q;
	logic [tpwm_pkg::TIME_W-1:0]  loaded_q;
	logic                         locked_q;
	logic                         level_q;

	// Captured request and tick intermediates.
	logic [2:0]                   op_q;
	logic [tpwm_pkg::TIME_W-1:0]  dur_q;
	logic [tpwm_pkg::CHAN_W-1:0]  mch_q;
	logic [tpwm_pkg::TIME_W-1:0]  ms_q;
	logic [tpwm_pkg::TIME_W-1:0]  delta_q;
	logic                         ms_gt_q;

	// Output register.
	logic                         out_valid_q;
	logic                         pin_level_q;
	logic                         finish_q;
	logic                         tick_q;
	logic [tpwm_pkg::TIME_W-1:0]  out_rem_q;
	logic [tpwm_pkg::TIME_W-1:0]  out_init_q;
	logic                         out_idle_q;

	tpwm_pkg::state_t state_q;
	tpwm_pkg::state_t state_nxt;

	logic                        accept;
	logic                        commit;
	logic                        div_start;
	logic                        div_done;
	logic [tpwm_pkg::TIME_W-1:0] div_quotient;

	logic [tpwm_pkg::TIME_W-1:0] nxt_rem;
	logic [tpwm_pkg::TIME_W-1:0] nxt_loaded;
	logic [tpwm_pkg::TIME_W-1:0] nxt_last_ms;
	logic                        nxt_locked;
	logic                        nxt_level;
	logic                        nxt_fin;
	logic                        nxt_tick;
	logic                        blocked;
	logic                        inactive;

	tpwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scaled_q),
		.divisor  (freq_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tpwm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (opcode == tpwm_pkg::OP_TICK) ? tpwm_pkg::ST_DIV
						: tpwm_pkg::ST_EXEC;
				end
			end
			tpwm_pkg::ST_DIV: begin
				if (div_done) begin
					state_nxt = tpwm_pkg::ST_DIFF;
				end
			end
			tpwm_pkg::ST_DIFF: begin
				state_nxt = tpwm_pkg::ST_EXEC;
			end
			tpwm_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = tpwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tpwm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = (state_q == tpwm_pkg::ST_IDLE);
		accept    = in_valid && in_ready;
		div_start = accept && (opcode == tpwm_pkg::OP_TICK);
		commit    = (state_q == tpwm_pkg::ST_EXEC) && (!out_valid_q || out_ready);
	end

	always_comb begin
		inactive    = ~active_q;
		blocked     = locked_q && (remaining_q != '0);
		nxt_rem     = remaining_q;
		nxt_loaded  = loaded_q;
		nxt_last_ms = last_ms_q;
		nxt_locked  = locked_q;
		nxt_level   = level_q;
		nxt_fin     = 1'b0;
		nxt_tick    = 1'b0;
		case (op_q)
			tpwm_pkg::OP_ON: begin
				if (!blocked) begin
					nxt_locked = 1'b0;
					if (remaining_q == '0 || !add_q) begin
						nxt_rem    = dur_q;
						nxt_loaded = dur_q;
					end else begin
						nxt_rem    = tpwm_pkg::sat_add(remaining_q, dur_q);
						nxt_loaded = tpwm_pkg::sat_add(loaded_q, dur_q);
					end
				end
			end
			tpwm_pkg::OP_OFF: begin
				if (!blocked) begin
					nxt_locked = 1'b0;
					nxt_fin    = 1'b1;
					nxt_rem    = '0;
					nxt_loaded = '0;
					nxt_level  = inactive;
				end
			end
			tpwm_pkg::OP_LOCK: begin
				nxt_locked = 1'b1;
			end
			tpwm_pkg::OP_TICK: begin
				if (remaining_q == '0) begin
					nxt_level = inactive;
				end else if (ms_gt_q && remaining_q <= delta_q) begin
					nxt_fin   = 1'b1;
					nxt_rem   = '0;
					nxt_level = inactive;
				end else begin
					if (ms_gt_q) begin
						nxt_rem  = remaining_q - delta_q;
						nxt_tick = 1'b1;
					end
					if (duty_q != '0) begin
						nxt_level = active_q;
					end
				end
				if (ms_gt_q) begin
					nxt_last_ms = ms_q;
				end
			end
			tpwm_pkg::OP_COMPARE: begin
				if (remaining_q != '0 && mch_q == chan_q && duty_q != tpwm_pkg::FULL_DUTY)
				begin
					nxt_level = inactive;
				end
			end
			default: begin
				nxt_level = level_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= tpwm_pkg::FREQ_RESET;
			add_q    <= 1'b0;
			duty_q   <= '0;
			chan_q   <= tpwm_pkg::CHAN_RESET;
			active_q <= tpwm_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tpwm_pkg::CFG_FREQ: begin
					if (cfg_data != '0) begin
						freq_q <= cfg_data;
					end
				end
				tpwm_pkg::CFG_ADD: begin
					add_q <= cfg_data[0];
				end
				tpwm_pkg::CFG_DUTY: begin
					if (cfg_data[tpwm_pkg::DUTY_W-1:0] <= tpwm_pkg::FULL_DUTY) begin
						duty_q <= cfg_data[tpwm_pkg::DUTY_W-1:0];
					end
				end
				tpwm_pkg::CFG_CHAN: begin
					if (cfg_data[tpwm_pkg::CHAN_W-1:0] inside
							{[tpwm_pkg::CHAN_LOW:tpwm_pkg::CHAN_HIGH]}) begin
						chan_q <= cfg_data[tpwm_pkg::CHAN_W-1:0];
					end
				end
				tpwm_pkg::CFG_ACTIVE: begin
					active_q <= cfg_data[0];
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaled_q    <= '0;
			last_ms_q   <= '0;
			remaining_q <= '0;
			loaded_q    <= '0;
			locked_q    <= 1'b0;
			level_q     <= ~tpwm_pkg::ACTIVE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= commit || (out_valid_q && !out_ready);
			if (commit) begin
				remaining_q <= nxt_rem;
				loaded_q    <= nxt_loaded;
				last_ms_q   <= nxt_last_ms;
				locked_q    <= nxt_locked;
				level_q     <= nxt_level;
				if (op_q == tpwm_pkg::OP_TICK) begin
					scaled_q <= scaled_q + tpwm_pkg::MS_PER_S;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			dur_q <= duration_ms;
			mch_q <= match_channel;
		end
		if (state_q == tpwm_pkg::ST_DIFF) begin
			ms_q    <= div_quotient;
			ms_gt_q <= div_quotient > last_ms_q;
			delta_q <= div_quotient - last_ms_q;
		end
		if (commit) begin
			pin_level_q <= nxt_level;
			finish_q    <= nxt_fin;
			tick_q      <= nxt_tick;
			out_rem_q   <= nxt_rem;
			out_init_q  <= nxt_loaded;
			out_idle_q  <= (nxt_rem == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign pin_level    = pin_level_q;
	assign finish_event = finish_q;
	assign tick_event   = tick_q;
	assign remaining_ms = out_rem_q;
	assign initial_ms   = out_init_q;
	assign idle         = out_idle_q;

	`ASSERT_CLK(a_idle_matches, out_valid |-> (idle == (remaining_ms == '0)), "idle flag disagrees with remaining time")
	`ASSERT_NEVER(a_fin_tick_excl, out_valid && finish_event && tick_event, "finish and tick reported together")
	`ASSERT_CLK(a_fin_clears, (out_valid && finish_event) |-> (remaining_ms == '0), "finished pulse left time")
	`ASSERT_CLK(a_commit_shows, commit |=> (out_valid && !in_ready || out_valid && in_ready), "committed result not shown")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of timed_pwm_pulse_output: a pulse scoreboard predicts every result,
// and plain tasks drive requests, register writes and random stalls. Depends on tpwm_pkg.

typedef struct packed {
	logic        pin;
	logic        finish;
	logic        ticked;
	logic [31:0] remaining;
	logic [31:0] loaded_ms;
	logic        idle;
} pulse_result_t;

class pulse_scoreboard;
	logic [19:0] freq_hz;
	logic        add_mode;
	logic [6:0]  duty;
	logic [2:0]  chan;
	logic        active_lvl;
	logic [63:0] tick_count;
	logic [31:0] last_ms;
	logic [31:0] remaining;
	logic [31:0] loaded;
	logic        locked;
	logic        pin;
	pulse_result_t predicted_results[$];
	int mismatches;
	int results_seen;

	function new();
		freq_hz = 20'd1;
		add_mode = 1'b0;
		duty = 7'd0;
		chan = 3'd1;
		active_lvl = 1'b1;
		tick_count = '0;
		last_ms = '0;
		remaining = '0;
		loaded = '0;
		locked = 1'b0;
		pin = 1'b0;
		mismatches = 0;
		results_seen = 0;
	endfunction

	function logic [31:0] add_saturated(logic [31:0] a, logic [31:0] b);
		logic [32:0] sum;
		sum = 33'(a) + 33'(b);
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function void note_config(logic [2:0] idx, logic [19:0] data);
		case (idx)
			tpwm_pkg::CFG_FREQ: if (data != '0) freq_hz = data;
			tpwm_pkg::CFG_ADD: add_mode = data[0];
			tpwm_pkg::CFG_DUTY: if (data[6:0] <= tpwm_pkg::FULL_DUTY) duty = data[6:0];
			tpwm_pkg::CFG_CHAN: begin
				if (data[2:0] >= tpwm_pkg::CHAN_LOW && data[2:0] <= tpwm_pkg::CHAN_HIGH)
					chan = data[2:0];
			end
			tpwm_pkg::CFG_ACTIVE: active_lvl = data[0];
			default: ;
		endcase
	endfunction

	function void note_request(logic [2:0] op, logic [31:0] dur, logic [2:0] mch);
		pulse_result_t r;
		logic [63:0] ms_full;
		logic [31:0] ms;
		logic [31:0] step_ms;
		logic ended;
		r = '0;
		case (op)
			tpwm_pkg::OP_ON: begin
				if (!(locked && remaining != 0)) begin
					locked = 1'b0;
					if (remaining == 0 || !add_mode) begin
						remaining = dur;
						loaded = dur;
					end else begin
						remaining = add_saturated(remaining, dur);
						loaded = add_saturated(loaded, dur);
					end
				end
			end
			tpwm_pkg::OP_OFF: begin
				if (!(locked && remaining != 0)) begin
					locked = 1'b0;
					r.finish = 1'b1;
					remaining = '0;
					loaded = '0;
					pin = ~active_lvl;
				end
			end
			tpwm_pkg::OP_LOCK: locked = 1'b1;
			tpwm_pkg::OP_TICK: begin
				ms_full = (tick_count * tpwm_pkg::MS_PER_S) / 64'(freq_hz);
				ms = ms_full[31:0];
				if (remaining == 0) begin
					pin = ~active_lvl;
				end else begin
					ended = 1'b0;
					if (ms > last_ms) begin
						step_ms = ms - last_ms;
						if (remaining > step_ms) begin
							remaining = remaining - step_ms;
							r.ticked = 1'b1;
						end else begin
							r.finish = 1'b1;
							remaining = '0;
							pin = ~active_lvl;
							ended = 1'b1;
						end
					end
					if (!ended && remaining != 0 && duty != 0)
						pin = active_lvl;
				end
				if (ms > last_ms)
					last_ms = ms;
				tick_count = tick_count + 64'd1;
			end
			tpwm_pkg::OP_COMPARE: begin
				if (remaining != 0 && mch == chan && duty != tpwm_pkg::FULL_DUTY)
					pin = ~active_lvl;
			end
			default: ;
		endcase
		r.pin = pin;
		r.remaining = remaining;
		r.loaded_ms = loaded;
		r.idle = (remaining == 0);
		predicted_results = {predicted_results, r};
	endfunction

	function int pending();
		return predicted_results.size();
	endfunction

	task report_mismatch(string what);
		$display("mismatch at result %0d: %s", results_seen, what);
		mismatches++;
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
	endtask

	task check_result(pulse_result_t got);
		pulse_result_t want;
		if (predicted_results.size() == 0) begin
			report_mismatch("result arrived with no request outstanding");
		end else begin
			want = predicted_results.pop_front();
			check_field("pin_level", 32'(got.pin), 32'(want.pin));
			check_field("finish_event", 32'(got.finish), 32'(want.finish));
			check_field("tick_event", 32'(got.ticked), 32'(want.ticked));
			check_field("remaining_ms", got.remaining, want.remaining);
			check_field("initial_ms", got.loaded_ms, want.loaded_ms);
			check_field("idle", 32'(got.idle), 32'(want.idle));
		end
		results_seen++;
	endtask
endclass

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int RANDOM_PHASES = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  opcode;
	logic [31:0] duration_ms;
	logic [2:0]  match_channel;
	logic        out_valid;
	logic        out_ready;
	logic        pin_level;
	logic        finish_event;
	logic        tick_event;
	logic [31:0] remaining_ms;
	logic [31:0] initial_ms;
	logic        idle;

	pulse_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;

	timed_pwm_pulse_output uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.duration_ms(duration_ms),
		.match_channel(match_channel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pin_level(pin_level),
		.finish_event(finish_event),
		.tick_event(tick_event),
		.remaining_ms(remaining_ms),
		.initial_ms(initial_ms),
		.idle(idle)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{pin_level, finish_event, tick_event, remaining_ms, initial_ms, idle});
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_request(input logic [2:0] op, input logic [31:0] dur,
			input logic [2:0] mch);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		duration_ms = dur;
		match_channel = mch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(op, dur, mch);
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.note_config(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_random(input logic [2:0] chan_now);
		int r;
		int dsel;
		logic [2:0] op;
		logic [31:0] dur;
		logic [2:0] mch;
		r = $urandom_range(99);
		if (r < 14)
			op = tpwm_pkg::OP_ON;
		else if (r < 18)
			op = tpwm_pkg::OP_OFF;
		else if (r < 21)
			op = tpwm_pkg::OP_LOCK;
		else if (r < 62)
			op = tpwm_pkg::OP_TICK;
		else if (r < 95)
			op = tpwm_pkg::OP_COMPARE;
		else
			op = 3'($urandom_range(5, 7));
		dsel = $urandom_range(99);
		if (op != tpwm_pkg::OP_ON)
			dur = $urandom;
		else if (dsel < 60)
			dur = $urandom_range(0, 50);
		else if (dsel < 85)
			dur = $urandom_range(0, 5000);
		else if (dsel < 95)
			dur = $urandom;
		else
			dur = '1;
		r = $urandom_range(9);
		if (r < 6)
			mch = chan_now;
		else if (r < 9)
			mch = 3'($urandom_range(1, 4));
		else
			mch = 3'($urandom_range(0, 7));
		send_request(op, dur, mch);
	endtask

	task automatic run_phase(input int idx);
		logic [19:0] freq;
		logic [6:0] duty;
		logic [2:0] chan;
		logic add;
		logic act;
		// Frequencies never rise from one phase to the next, so the elapsed
		// milliseconds keep growing and the pulse keeps counting down.
		case (idx)
			0: freq = 20'd1000000;
			1: freq = 20'($urandom_range(200000, 900000));
			2: freq = 20'($urandom_range(20000, 100000));
			3: freq = 20'($urandom_range(1000, 5000));
			4: freq = 20'd1000;
			5: freq = 20'($urandom_range(10, 200));
			6: freq = 20'd2;
			default: freq = 20'd1;
		endcase
		case (idx % 3)
			0: duty = 7'($urandom_range(1, 99));
			1: duty = tpwm_pkg::FULL_DUTY;
			default: duty = 7'd0;
		endcase
		chan = 3'($urandom_range(1, 4));
		add = idx[0];
		act = 1'($urandom_range(1));
		case (idx % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 87;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 87;
			end
			default: begin
				send_idle_pct = 28;
				recv_stall_pct = 28;
			end
		endcase
		write_reg(3'($urandom_range(1, 7)), 20'($urandom));
		write_reg(tpwm_pkg::CFG_FREQ, freq);
		write_reg(tpwm_pkg::CFG_ADD, {19'($urandom), add});
		write_reg(tpwm_pkg::CFG_DUTY, {13'($urandom), duty});
		write_reg(tpwm_pkg::CFG_CHAN, {17'($urandom), chan});
		write_reg(tpwm_pkg::CFG_ACTIVE, {19'($urandom), act});
		if (idx == RANDOM_PHASES - 1) begin
			// A locked pulse ignores on and off until it runs out on a tick.
			send_request(tpwm_pkg::OP_ON, 32'd1500, chan);
			send_request(tpwm_pkg::OP_LOCK, 32'd0, chan);
			send_request(tpwm_pkg::OP_ON, 32'd9, chan);
			send_request(tpwm_pkg::OP_OFF, 32'd0, chan);
			send_request(tpwm_pkg::OP_TICK, 32'd0, chan);
			send_request(tpwm_pkg::OP_TICK, 32'd0, chan);
			send_request(tpwm_pkg::OP_ON, 32'd5, chan);
		end
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			if (i == ITEMS_PER_PHASE / 2 && idx % 2 == 1)
				drain(0);
			send_random(chan);
		end
		drain(SETTLE_CYCLES);
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tpwm_pkg::CFG_FREQ;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = tpwm_pkg::OP_ON;
		duration_ms = '0;
		match_channel = 3'd1;
		out_ready = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(tpwm_pkg::OP_TICK, 32'd0, 3'd1);
		send_request(3'($urandom_range(5, 5)), 32'hFFFF_FFFF, 3'd7);
		send_request(3'($urandom_range(7, 7)), 32'd0, 3'd0);
		send_request(tpwm_pkg::OP_OFF, 32'd0, 3'd1);
		send_request(tpwm_pkg::OP_COMPARE, 32'd0, 3'd1);
		send_request(tpwm_pkg::OP_ON, 32'd3000, 3'd1);
		send_request(tpwm_pkg::OP_COMPARE, 32'd0, 3'd1);
		send_request(tpwm_pkg::OP_COMPARE, 32'd0, 3'd3);
		send_request(tpwm_pkg::OP_OFF, 32'd0, 3'd1);
		send_request(tpwm_pkg::OP_LOCK, 32'd0, 3'd1);
		send_request(tpwm_pkg::OP_ON, 32'd20, 3'd1);
		send_request(3'($urandom_range(6, 6)), 32'd0, 3'd4);
		drain(SETTLE_CYCLES);

		write_reg(tpwm_pkg::CFG_FREQ, 20'd0);
		write_reg(tpwm_pkg::CFG_DUTY, 20'd101);
		write_reg(tpwm_pkg::CFG_DUTY, 20'd127);
		write_reg(tpwm_pkg::CFG_CHAN, 20'd0);
		write_reg(tpwm_pkg::CFG_CHAN, 20'd5);
		write_reg(3'($urandom_range(5, 7)), 20'hFFFFF);
		write_reg(tpwm_pkg::CFG_FREQ, 20'hFFFFF);
		write_reg(tpwm_pkg::CFG_ADD, 20'd1);
		write_reg(tpwm_pkg::CFG_DUTY, 20'(tpwm_pkg::FULL_DUTY));
		write_reg(tpwm_pkg::CFG_CHAN, 20'd4);
		write_reg(tpwm_pkg::CFG_ACTIVE, 20'd0);

		send_request(tpwm_pkg::OP_TICK, 32'd0, 3'd4);
		send_request(tpwm_pkg::OP_COMPARE, 32'd0, 3'd4);
		send_request(tpwm_pkg::OP_ON, 32'hFFFF_FFFF, 3'd4);
		send_request(tpwm_pkg::OP_ON, 32'd1, 3'd4);
		send_request(tpwm_pkg::OP_OFF, 32'd0, 3'd4);
		send_request(tpwm_pkg::OP_ON, 32'h8000_0000, 3'd4);
		send_request(tpwm_pkg::OP_ON, 32'h8000_0000, 3'd4);
		send_request(tpwm_pkg::OP_OFF, 32'd0, 3'd4);
		send_request(tpwm_pkg::OP_LOCK, 32'd0, 3'd4);
		send_request(tpwm_pkg::OP_ON, 32'd9, 3'd4);
		send_request(tpwm_pkg::OP_COMPARE, 32'd0, 3'd4);
		send_request(tpwm_pkg::OP_TICK, 32'd0, 3'd4);
		drain(SETTLE_CYCLES);

		for (int p = 0; p < RANDOM_PHASES; p++)
			run_phase(p);

		if (sb.pending() != 0)
			sb.report_mismatch("requests left without a result");
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
